// ----- rtl/esc_pkg.sv -----
// Shared constants, field helpers and types for the sensor compensation pipeline.
package esc_pkg;

  // Divider: one stage to take magnitudes, then one quotient bit per stage
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 1;

  // Divide by 100: magnitude, reciprocal multiply, sign fix-up
  localparam int unsigned DIV100_LAT = 3;

  // Pipeline depth from input register to output register
  localparam int unsigned NUM_STAGES = 48;
  localparam int unsigned LAST_STAGE = NUM_STAGES - 1;

  // Delay lines to the output register
  localparam int unsigned TEMP_DLY = 42;
  localparam int unsigned HUM_DLY  = 28;

  localparam int unsigned CFG_W   = 56;
  localparam int unsigned CFG_IDX = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX-1:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRES_CAL_A = 3'd1,
    REG_PRES_CAL_B = 3'd2,
    REG_PRES_CAL_C = 3'd3,
    REG_HUM_CAL_A = 3'd4,
    REG_HUM_CAL_B = 3'd5
  } cfg_reg_e;

  localparam logic [31:0] PRES_OFFSET = 32'd64000;
  localparam logic [31:0] PRES_FULL   = 32'd1048576;
  localparam logic [31:0] PRES_SCALE  = 32'd3125;
  localparam logic [31:0] PRES_ONE    = 32'd32768;
  localparam logic [31:0] TEMP_ROUND  = 32'd128;
  localparam logic [31:0] HUM_ONE     = 32'd16384;
  localparam logic [31:0] HUM_MILLI   = 32'd1000;
  localparam logic [16:0] HUM_MAX     = 17'd100000;

  // ceil(2^37 / 100): exact floor division by 100 for any 32-bit magnitude
  localparam logic [31:0] HUM_RECIP       = 32'h51EB_851F;
  localparam int unsigned HUM_RECIP_SHIFT = 37;

  // Sign extension of packed calibration fields
  function automatic logic [31:0] sx8(input logic [7:0] v);
    sx8 = {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit two's-complement word
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    logic signed [31:0] t;
    t   = $signed(v) >>> s;
    asr = t;
  endfunction

endpackage

// ----- rtl/esc_in_if.sv -----
// Input frame channel: raw conversion results with valid/ready.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source(output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

// ----- rtl/esc_out_if.sv -----
// Output result channel: compensated readings with valid/ready.
interface esc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic [16:0]        humidity_milli;
  logic signed [31:0] pressure_pa;
  logic               pressure_invalid;

  modport source(output valid, temperature_centi, humidity_milli, pressure_pa,
                 pressure_invalid, input ready);
  modport sink(input valid, temperature_centi, humidity_milli, pressure_pa,
               pressure_invalid, output ready);
endinterface

// ----- rtl/esc_div.sv -----
// Pipelined 32-bit signed dividers, truncating: general bit-per-stage and by 100.
module esc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o
);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dvd;   // remaining dividend bits, quotient bits shift in below
    logic [31:0] dvs;
    logic        neg;
    logic        zero;
  } step_t;

  step_t st_q [esc_pkg::DIV_LAT];
  step_t st0;

  function automatic step_t div_step(input step_t s);
    step_t       r;
    logic [32:0] sh;
    logic        take;
    r    = s;
    sh   = {s.rem, s.dvd[31]};
    take = (sh >= {1'b0, s.dvs});
    r.rem = take ? 32'(sh - {1'b0, s.dvs}) : sh[31:0];
    r.dvd = {s.dvd[30:0], take};
    return r;
  endfunction

  // Magnitudes and result sign
  always_comb begin
    st0.rem  = '0;
    st0.dvd  = dividend_i[31] ? 32'(0 - dividend_i) : dividend_i;
    st0.dvs  = divisor_i[31] ? 32'(0 - divisor_i) : divisor_i;
    st0.neg  = dividend_i[31] ^ divisor_i[31];
    st0.zero = (divisor_i == '0);
  end

  // Bit stages advance together with the enclosing pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0;
      for (int k = 1; k < esc_pkg::DIV_LAT; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
    end
  end

  // Sign fix-up; zero divisor gives zero
  always_comb begin
    if (st_q[esc_pkg::DIV_LAT-1].zero) begin
      quotient_o = '0;
    end else if (st_q[esc_pkg::DIV_LAT-1].neg) begin
      quotient_o = 32'(0 - st_q[esc_pkg::DIV_LAT-1].dvd);
    end else begin
      quotient_o = st_q[esc_pkg::DIV_LAT-1].dvd;
    end
  end

endmodule

// Signed divide by 100 through a reciprocal multiply, three register stages.
module esc_div100 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  output logic [31:0] quotient_o
);

  logic        neg_q, neg2_q;
  logic [31:0] mag_q, q_q, quot_q;
  logic [63:0] prod;

  // floor(mag / 100) is the top bits of the reciprocal product
  assign prod = {32'd0, mag_q} * {32'd0, esc_pkg::HUM_RECIP};

  // magnitude, multiply, then restore the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= dividend_i[31];
      mag_q  <= dividend_i[31] ? 32'(0 - dividend_i) : dividend_i;
      neg2_q <= neg_q;
      q_q    <= 32'(prod[63:esc_pkg::HUM_RECIP_SHIFT]);
      quot_q <= neg2_q ? 32'(0 - q_q) : q_q;
    end
  end

  assign quotient_o = quot_q;

endmodule

// ----- rtl/env_sensor_compensation.sv -----
// Top level: integer temperature, pressure and humidity compensation pipeline.
//
// Usage: raw frames (20-bit temperature, 20-bit pressure, 16-bit humidity)
// arrive on in_i; one result per frame leaves on out_o, in order. A transfer
// happens on each edge with valid and ready high on a channel.
// Calibration words are loaded through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must load them only while no frame is in flight; the block itself
// does not enforce this. Indexes beyond the list are ignored. Throughput is
// one frame per cycle while the receiver does not stall. Depth is set by
// the pressure path: 5 temperature stages, 5 pressure stages, the 33-stage
// bit-per-stage divider, 4 correction stages and the output register.
// Humidity divides by 100 with reciprocal multiplies and is done by stage
// 19; it and temperature wait in delay lines for the pressure result.
// Reset clears all stage valid bits and calibration registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; ready is high only while the last stage is empty
// or being taken, so bubbles inside the pipeline are not squeezed out.
module env_sensor_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  esc_in_if.sink                       in_i,
  esc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [esc_pkg::CFG_IDX-1:0]  cfg_idx_i,
  input  logic [esc_pkg::CFG_W-1:0]    cfg_wdata_i
);

  // Calibration registers
  logic [39:0] tcal_q, hcal_a_q;
  logic [55:0] pcal_a_q;
  logic [47:0] pcal_b_q;
  logic [23:0] pcal_c_q, hcal_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q   <= '0;
      pcal_a_q <= '0;
      pcal_b_q <= '0;
      pcal_c_q <= '0;
      hcal_a_q <= '0;
      hcal_b_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        esc_pkg::REG_TEMP_CAL:   tcal_q   <= cfg_wdata_i[39:0];
        esc_pkg::REG_PRES_CAL_A: pcal_a_q <= cfg_wdata_i[55:0];
        esc_pkg::REG_PRES_CAL_B: pcal_b_q <= cfg_wdata_i[47:0];
        esc_pkg::REG_PRES_CAL_C: pcal_c_q <= cfg_wdata_i[23:0];
        esc_pkg::REG_HUM_CAL_A:  hcal_a_q <= cfg_wdata_i[39:0];
        esc_pkg::REG_HUM_CAL_B:  hcal_b_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // Unpacked coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
  logic [31:0] h1, h2, h3, h4, h5, h6, h7;
  assign t1  = {16'd0, tcal_q[15:0]};
  assign t2  = esc_pkg::sx16(tcal_q[31:16]);
  assign t3  = esc_pkg::sx8(tcal_q[39:32]);
  assign p1  = {16'd0, pcal_a_q[15:0]};
  assign p2  = esc_pkg::sx16(pcal_a_q[31:16]);
  assign p3  = esc_pkg::sx8(pcal_a_q[39:32]);
  assign p4  = esc_pkg::sx16(pcal_a_q[55:40]);
  assign p5  = esc_pkg::sx16(pcal_b_q[15:0]);
  assign p6  = esc_pkg::sx8(pcal_b_q[23:16]);
  assign p7  = esc_pkg::sx8(pcal_b_q[31:24]);
  assign p8  = esc_pkg::sx16(pcal_b_q[47:32]);
  assign p9  = esc_pkg::sx16(pcal_c_q[15:0]);
  assign p10 = {24'd0, pcal_c_q[23:16]};
  assign h1  = {20'd0, hcal_a_q[11:0]};
  assign h2  = {20'd0, hcal_a_q[23:12]};
  assign h3  = esc_pkg::sx8(hcal_a_q[31:24]);
  assign h4  = esc_pkg::sx8(hcal_a_q[39:32]);
  assign h5  = esc_pkg::sx8(hcal_b_q[7:0]);
  assign h6  = {24'd0, hcal_b_q[15:8]};
  assign h7  = esc_pkg::sx8(hcal_b_q[23:16]);

  // Stage valid bits and global advance
  logic                        en;
  logic [esc_pkg::NUM_STAGES-1:0] v_q;
  assign en       = !v_q[esc_pkg::LAST_STAGE] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[esc_pkg::LAST_STAGE-1:0], in_i.valid};
    end
  end

  // ---------------- temperature, stages 1..5 ----------------
  logic [31:0] r1_a_q, r2_m1_q, r2_m2_q, r3_b_q, r3_m3_q, r4_tf_q, r5_ts_q, r5_pa_q;
  logic [19:0] r1_rp_q, r2_rp_q, r3_rp_q, r4_rp_q, r5_rp_q, r6_rp_q, r7_rp_q, r8_rp_q;
  logic [15:0] r1_rh_q, r2_rh_q, r3_rh_q, r4_rh_q, r5_rh_q;
  logic [31:0] r2_c;
  assign r2_c = esc_pkg::asr(r1_a_q, 5'd1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_a_q  <= 32'(in_i.raw_temperature >> 3) - (t1 << 1);
      r1_rp_q <= in_i.raw_pressure;
      r1_rh_q <= in_i.raw_humidity;
      r2_m1_q <= r1_a_q * t2;
      r2_m2_q <= r2_c * r2_c;
      r2_rp_q <= r1_rp_q;
      r2_rh_q <= r1_rh_q;
      r3_b_q  <= esc_pkg::asr(r2_m1_q, 5'd11);
      r3_m3_q <= esc_pkg::asr(r2_m2_q, 5'd12) * (t3 << 4);
      r3_rp_q <= r2_rp_q;
      r3_rh_q <= r2_rh_q;
      r4_tf_q <= r3_b_q + esc_pkg::asr(r3_m3_q, 5'd14);
      r4_rp_q <= r3_rp_q;
      r4_rh_q <= r3_rh_q;
      r5_ts_q <= esc_pkg::asr(r4_tf_q * 32'd5 + esc_pkg::TEMP_ROUND, 5'd8);
      r5_pa_q <= esc_pkg::asr(r4_tf_q, 5'd1) - esc_pkg::PRES_OFFSET;
      r5_rp_q <= r4_rp_q;
      r5_rh_q <= r4_rh_q;
    end
  end

  // Saturated temperature, carried to the output
  logic [15:0] tsat;
  logic [15:0] td_q [esc_pkg::TEMP_DLY];
  always_comb begin
    if ($signed(r5_ts_q) > 32'sd32767) begin
      tsat = 16'h7FFF;
    end else if ($signed(r5_ts_q) < -32'sd32768) begin
      tsat = 16'h8000;
    end else begin
      tsat = r5_ts_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      td_q[0] <= tsat;
      for (int i = 1; i < esc_pkg::TEMP_DLY; i++) begin
        td_q[i] <= td_q[i-1];
      end
    end
  end

  // ---------------- pressure, stages 6..10 ----------------
  logic [31:0] r6_sq_q, r6_mp5_q, r6_mp2_q, r7_mb_q, r7_ma_q, r7_mp5_q, r7_mp2_q;
  logic [31:0] r8_b_q, r8_a_q, r9_pam_q, r9_pcs_q, r10_dv_q, r10_pc_q;
  logic [31:0] r6_c;
  assign r6_c = esc_pkg::asr(r5_pa_q, 5'd2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r6_sq_q  <= r6_c * r6_c;
      r6_mp5_q <= r5_pa_q * p5;
      r6_mp2_q <= p2 * r5_pa_q;
      r6_rp_q  <= r5_rp_q;
      r7_mb_q  <= esc_pkg::asr(r6_sq_q, 5'd11) * p6;
      r7_ma_q  <= esc_pkg::asr(r6_sq_q, 5'd13) * (p3 << 5);
      r7_mp5_q <= r6_mp5_q;
      r7_mp2_q <= r6_mp2_q;
      r7_rp_q  <= r6_rp_q;
      r8_b_q   <= esc_pkg::asr(esc_pkg::asr(r7_mb_q, 5'd2) + (r7_mp5_q << 1), 5'd2)
                  + (p4 << 16);
      r8_a_q   <= esc_pkg::asr(esc_pkg::asr(r7_ma_q, 5'd3) + esc_pkg::asr(r7_mp2_q, 5'd1),
                               5'd18);
      r8_rp_q  <= r7_rp_q;
      r9_pam_q <= (esc_pkg::PRES_ONE + r8_a_q) * p1;
      r9_pcs_q <= (esc_pkg::PRES_FULL - 32'(r8_rp_q)) - esc_pkg::asr(r8_b_q, 5'd12);
      r10_dv_q <= esc_pkg::asr(r9_pam_q, 5'd15);
      r10_pc_q <= r9_pcs_q * esc_pkg::PRES_SCALE;
    end
  end

  // Divide: large positive dividends are divided first and doubled after
  typedef struct packed {
    logic inv;
    logic dbl;
  } pside_t;

  logic        pbig;
  logic [31:0] pdvd, pq;
  pside_t      pside;
  pside_t      ps_q [esc_pkg::DIV_LAT];

  assign pbig      = (r10_pc_q[31:30] == 2'b01);
  assign pdvd      = pbig ? r10_pc_q : (r10_pc_q << 1);
  assign pside.inv = (r10_dv_q == '0);
  assign pside.dbl = pbig;

  esc_div u_pdiv (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (pdvd),
    .divisor_i  (r10_dv_q),
    .quotient_o (pq)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= pside;
      for (int i = 1; i < esc_pkg::DIV_LAT; i++) begin
        ps_q[i] <= ps_q[i-1];
      end
    end
  end

  // ---------------- pressure correction, stages 44..47 ----------------
  logic [31:0] r44_pc_q, r45_pc_q, r46_pc_q, r47_pc_q;
  logic [31:0] r45_m_q, r45_m2_q, r45_c8_q, r45_m3_q;
  logic [31:0] r46_x1m_q, r46_x2_q, r46_m3b_q, r47_x1_q, r47_x2_q, r47_x3m_q;
  logic        r44_inv_q, r45_inv_q, r46_inv_q, r47_inv_q;
  logic [31:0] r45_c3, r45_c8, pfin;
  assign r45_c3 = esc_pkg::asr(r44_pc_q, 5'd3);
  assign r45_c8 = esc_pkg::asr(r44_pc_q, 5'd8);
  assign pfin   = r47_inv_q ? '0 :
                  r47_pc_q + esc_pkg::asr(r47_x1_q + r47_x2_q
                  + esc_pkg::asr(r47_x3m_q, 5'd17) + (p7 << 7), 5'd4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r44_pc_q  <= ps_q[esc_pkg::DIV_LAT-1].dbl ? (pq << 1) : pq;
      r44_inv_q <= ps_q[esc_pkg::DIV_LAT-1].inv;
      r45_m_q   <= r45_c3 * r45_c3;
      r45_m2_q  <= esc_pkg::asr(r44_pc_q, 5'd2) * p8;
      r45_c8_q  <= r45_c8;
      r45_m3_q  <= r45_c8 * r45_c8;
      r45_pc_q  <= r44_pc_q;
      r45_inv_q <= r44_inv_q;
      r46_x1m_q <= p9 * esc_pkg::asr(r45_m_q, 5'd13);
      r46_x2_q  <= esc_pkg::asr(r45_m2_q, 5'd13);
      r46_m3b_q <= r45_m3_q * r45_c8_q;
      r46_pc_q  <= r45_pc_q;
      r46_inv_q <= r45_inv_q;
      r47_x1_q  <= esc_pkg::asr(r46_x1m_q, 5'd12);
      r47_x2_q  <= r46_x2_q;
      r47_x3m_q <= r46_m3b_q * p10;
      r47_pc_q  <= r46_pc_q;
      r47_inv_q <= r46_inv_q;
    end
  end

  // ---------------- humidity, stages 6..13: divides by 100 ----------------
  logic [31:0] r6_mh3_q, r6_mh4_q, r6_mh5_q, r6_mh7_q;
  logic [31:0] d1, d2, d3, d4, d5;

  typedef struct packed {
    logic [31:0] ts;
    logic [15:0] rh;
  } hside1_t;

  typedef struct packed {
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] d5;
    logic [15:0] rh;
  } hside2_t;

  hside1_t r6_h_q;
  hside1_t hd1_q [esc_pkg::DIV100_LAT];
  hside2_t r10_hs_q;
  hside2_t hd2_q [esc_pkg::DIV100_LAT];
  logic [31:0] r10_hr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r6_mh3_q <= r5_ts_q * h3;
      r6_mh4_q <= r5_ts_q * h4;
      r6_mh5_q <= r5_ts_q * h5;
      r6_mh7_q <= r5_ts_q * h7;
      r6_h_q   <= '{ts: r5_ts_q, rh: r5_rh_q};
    end
  end

  esc_div100 u_hdiv3 (.clk_i(clk_i), .en_i(en), .dividend_i(r6_mh3_q), .quotient_o(d1));
  esc_div100 u_hdiv4 (.clk_i(clk_i), .en_i(en), .dividend_i(r6_mh4_q), .quotient_o(d2));
  esc_div100 u_hdiv5 (.clk_i(clk_i), .en_i(en), .dividend_i(r6_mh5_q), .quotient_o(d3));
  esc_div100 u_hdiv7 (.clk_i(clk_i), .en_i(en), .dividend_i(r6_mh7_q), .quotient_o(d5));

  // Second-order term needs its own divide after the first ones
  always_ff @(posedge clk_i) begin
    if (en) begin
      hd1_q[0] <= r6_h_q;
      for (int i = 1; i < esc_pkg::DIV100_LAT; i++) begin
        hd1_q[i] <= hd1_q[i-1];
      end
      r10_hr_q <= hd1_q[esc_pkg::DIV100_LAT-1].ts * d3;
      r10_hs_q <= '{d1: d1, d2: d2, d5: d5, rh: hd1_q[esc_pkg::DIV100_LAT-1].rh};
      hd2_q[0] <= r10_hs_q;
      for (int i = 1; i < esc_pkg::DIV100_LAT; i++) begin
        hd2_q[i] <= hd2_q[i-1];
      end
    end
  end

  esc_div100 u_hdiv_sq (.clk_i(clk_i), .en_i(en),
                        .dividend_i(esc_pkg::asr(r10_hr_q, 5'd6)), .quotient_o(d4));

  // ---------------- humidity polynomial, stages 14..19 ----------------
  hside2_t     hh;
  logic [31:0] r14_x1_q, r14_x2s_q, r14_x4_q, r15_x1_q, r15_x2m_q, r15_x4_q;
  logic [31:0] r16_x3_q, r16_x4_q, r17_x3_q, r17_x4_q, r17_x5m_q;
  logic [31:0] r18_x3_q, r18_x6m_q, r19_hm_q;
  logic [31:0] r17_y, hc;
  logic [16:0] hclamp;
  logic [16:0] hum_q [esc_pkg::HUM_DLY];
  assign hh    = hd2_q[esc_pkg::DIV100_LAT-1];
  assign r17_y = esc_pkg::asr(r16_x3_q, 5'd14);
  assign hc    = esc_pkg::asr(r19_hm_q, 5'd12);

  always_comb begin
    if ($signed(hc) > $signed({15'd0, esc_pkg::HUM_MAX})) begin
      hclamp = esc_pkg::HUM_MAX;
    end else if (hc[31]) begin
      hclamp = '0;
    end else begin
      hclamp = hc[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r14_x1_q  <= 32'(hh.rh) - (h1 << 4) - esc_pkg::asr(hh.d1, 5'd1);
      r14_x2s_q <= hh.d2 + d4 + esc_pkg::HUM_ONE;
      r14_x4_q  <= esc_pkg::asr((h6 << 7) + hh.d5, 5'd4);
      r15_x2m_q <= h2 * r14_x2s_q;
      r15_x1_q  <= r14_x1_q;
      r15_x4_q  <= r14_x4_q;
      r16_x3_q  <= r15_x1_q * esc_pkg::asr(r15_x2m_q, 5'd10);
      r16_x4_q  <= r15_x4_q;
      r17_x5m_q <= r17_y * r17_y;
      r17_x3_q  <= r16_x3_q;
      r17_x4_q  <= r16_x4_q;
      r18_x6m_q <= r17_x4_q * esc_pkg::asr(r17_x5m_q, 5'd10);
      r18_x3_q  <= r17_x3_q;
      r19_hm_q  <= esc_pkg::asr(r18_x3_q + esc_pkg::asr(r18_x6m_q, 5'd1), 5'd10)
                   * esc_pkg::HUM_MILLI;
    end
  end

  // Clamped humidity, carried to the output
  always_ff @(posedge clk_i) begin
    if (en) begin
      hum_q[0] <= hclamp;
      for (int i = 1; i < esc_pkg::HUM_DLY; i++) begin
        hum_q[i] <= hum_q[i-1];
      end
    end
  end

  // Output register
  logic [15:0] o_temp_q;
  logic [16:0] o_hum_q;
  logic [31:0] o_pres_q;
  logic        o_inv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_temp_q <= td_q[esc_pkg::TEMP_DLY-1];
      o_hum_q  <= hum_q[esc_pkg::HUM_DLY-1];
      o_pres_q <= pfin;
      o_inv_q  <= r47_inv_q;
    end
  end

  assign out_o.valid             = v_q[esc_pkg::LAST_STAGE];
  assign out_o.temperature_centi = o_temp_q;
  assign out_o.humidity_milli    = o_hum_q;
  assign out_o.pressure_pa       = o_pres_q;
  assign out_o.pressure_invalid  = o_inv_q;

  // Checks
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.pressure_invalid |-> out_o.pressure_pa == 32'sd0)
    else $error("invalid pressure result is not zero");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.humidity_milli <= esc_pkg::HUM_MAX)
    else $error("humidity out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during stall");

endmodule
